// ----- src/llrgs_pkg.sv -----
// ----------------------------------------------------------------------------
// llrgs_pkg
// Shared types and constants of the letter run grid scan unit.
// ----------------------------------------------------------------------------
package llrgs_pkg;

    localparam int CHAR_W      = 8;
    localparam int CFG_W       = 11;
    localparam int LEN_OUT_W   = 11;
    localparam int POS_OUT_W   = 10;
    localparam int DIR_W       = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 11'd1024;

    typedef enum logic [0:0] {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } reg_index_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_DIAG  = 2'd2,
        DIR_ANTI  = 2'd3
    } dir_t;

    function automatic logic is_letter(input logic [CHAR_W-1:0] ch);
        return ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
    endfunction

endpackage

// ----- src/llrgs_front.sv -----
// ----------------------------------------------------------------------------
// llrgs_front
// Takes cell requests, tracks the raster position and grid size registers,
// and tags each cell with its position, letter flag and edge flags.
// ----------------------------------------------------------------------------
module llrgs_front
    import llrgs_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [CHAR_W-1:0]             s_cell_char,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  reg_index_t                    cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    output logic                          q_push,
    output logic [2*$clog2(MAX_DIM)+2:0]  q_data,
    input  logic                          q_full
);

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             letter;
        logic             last;
        logic             anti_ok;
    } item_t;

    logic [CFG_W-1:0] grid_rows_reg, grid_cols_reg;
    logic [POS_W-1:0] row_reg, col_reg;
    logic [DIM_W-1:0] rows_eff, cols_eff, row_p1, col_p1;
    logic             col_end, row_end, accept;
    item_t            item;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    assign rows_eff  = clamp_dim(grid_rows_reg);
    assign cols_eff  = clamp_dim(grid_cols_reg);
    assign row_p1    = DIM_W'(row_reg) + DIM_W'(1);
    assign col_p1    = DIM_W'(col_reg) + DIM_W'(1);
    assign col_end   = (col_p1 >= cols_eff);
    assign row_end   = (row_p1 >= rows_eff);

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        item.row     = row_reg;
        item.col     = col_reg;
        item.letter  = is_letter(s_cell_char);
        item.last    = col_end && row_end;
        // anti-diagonal neighbour's column lies inside the grid
        item.anti_ok = (col_p1 < cols_eff) && (col_p1 < DIM_W'(MAX_DIM));
    end

    assign q_push = accept;
    assign q_data = item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= CFG_DIM_RESET;
            grid_cols_reg <= CFG_DIM_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            if (col_end) begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : POS_W'(row_p1);
            end else begin
                col_reg <= POS_W'(col_p1);
            end
        end
    end

endmodule

// ----- src/llrgs_queue.sv -----
// ----------------------------------------------------------------------------
// llrgs_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module llrgs_queue
    import llrgs_pkg::*;
#(
    parameter int DATA_W = 23
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg, count_next;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/llrgs_back.sv -----
// ----------------------------------------------------------------------------
// llrgs_back
// Line buffer reads, run counting, best run selection and the result
// register. Stage two counts runs, stage three merges into the best run.
// ----------------------------------------------------------------------------
module llrgs_back
    import llrgs_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  logic [2*$clog2(MAX_DIM)+2:0]  q_data,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [LEN_OUT_W-1:0]          m_run_length,
    output logic [POS_OUT_W-1:0]          m_start_row,
    output logic [POS_OUT_W-1:0]          m_start_col,
    output logic [DIR_W-1:0]              m_direction
);

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int LEN_W = $clog2(MAX_DIM + 1);
    localparam int SUM_W = LEN_W + 1;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             letter;
        logic             last;
        logic             anti_ok;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        dir_t             dir;
    } cand_t;

    localparam cand_t BEST_RESET = '{len: '0, row: '0, col: '0, dir: DIR_RIGHT};

    // line buffers, one entry per column
    logic [LEN_W-1:0] down_mem [MAX_DIM];
    logic [LEN_W-1:0] diag_mem [MAX_DIM];
    logic [LEN_W-1:0] anti_mem [MAX_DIM];

    item_t            head, s2_item_reg;
    logic [POS_W-1:0] head_anti_addr;
    logic             s2_valid_reg, s3_valid_reg, s3_last_reg, s3_cand_valid_reg;
    cand_t            s3_cand_reg, best_reg;
    logic [LEN_W-1:0] down_q_reg, diag_q_reg, anti_q_reg;
    logic [LEN_W-1:0] down_byp_data_reg, diag_byp_data_reg, anti_byp_data_reg;
    logic             down_byp_reg, diag_byp_reg, anti_byp_reg;
    logic [LEN_W-1:0] left_run_reg, diag_hold_reg;

    logic                 m_valid_reg, m_found_reg;
    logic [LEN_OUT_W-1:0] m_run_length_reg;
    logic [POS_OUT_W-1:0] m_start_row_reg, m_start_col_reg;
    logic [DIR_W-1:0]     m_direction_reg;

    logic             stall, advance, wr_en;
    logic [LEN_W-1:0] down_val, diag_val, anti_val;
    logic [LEN_W-1:0] lf, up, dl, ar;
    logic [LEN_W-1:0] nr, nd, ng, na;
    logic [SUM_W-1:0] r1, c1, rc1;
    cand_t            cand0, cand1, cand2, cand3, win01, win23, win, merged;
    logic             found;

    function automatic logic [SUM_W-1:0] min_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // longer wins, then earlier start, then lower direction code
    function automatic logic beats(input cand_t a, input cand_t b);
        return {a.len, ~a.row, ~a.col, ~a.dir} > {b.len, ~b.row, ~b.col, ~b.dir};
    endfunction

    assign head           = item_t'(q_data);
    assign head_anti_addr = head.col + POS_W'(1);

    assign stall   = s3_valid_reg && s3_last_reg && m_valid_reg && !m_ready;
    assign advance = !stall;
    assign q_pop   = q_valid && advance;
    assign wr_en   = s2_valid_reg && advance;

    // ---------------- stage two: run counts ----------------
    assign down_val = down_byp_reg ? down_byp_data_reg : down_q_reg;
    assign diag_val = diag_byp_reg ? diag_byp_data_reg : diag_q_reg;
    assign anti_val = anti_byp_reg ? anti_byp_data_reg : anti_q_reg;

    always_comb begin
        lf  = (s2_item_reg.col != '0) ? left_run_reg : '0;
        up  = (s2_item_reg.row != '0) ? down_val : '0;
        dl  = ((s2_item_reg.row != '0) && (s2_item_reg.col != '0)) ? diag_hold_reg : '0;
        ar  = ((s2_item_reg.row != '0) && s2_item_reg.anti_ok) ? anti_val : '0;
        r1  = SUM_W'(s2_item_reg.row) + SUM_W'(1);
        c1  = SUM_W'(s2_item_reg.col) + SUM_W'(1);
        rc1 = ((s2_item_reg.row < s2_item_reg.col) ? SUM_W'(s2_item_reg.row)
                                                   : SUM_W'(s2_item_reg.col)) + SUM_W'(1);
        nr  = '0;
        nd  = '0;
        ng  = '0;
        na  = '0;
        if (s2_item_reg.letter) begin
            // each count is capped by what the grid edge allows
            nr = LEN_W'(min_sum(SUM_W'(lf) + SUM_W'(1), c1));
            nd = LEN_W'(min_sum(SUM_W'(up) + SUM_W'(1), r1));
            ng = LEN_W'(min_sum(SUM_W'(dl) + SUM_W'(1), rc1));
            na = LEN_W'(min_sum(SUM_W'(ar) + SUM_W'(1), r1));
        end
    end

    always_comb begin
        cand0.len = nr;
        cand0.row = s2_item_reg.row;
        cand0.col = POS_W'(c1 - SUM_W'(nr));
        cand0.dir = DIR_RIGHT;
        cand1.len = nd;
        cand1.row = POS_W'(r1 - SUM_W'(nd));
        cand1.col = s2_item_reg.col;
        cand1.dir = DIR_DOWN;
        cand2.len = ng;
        cand2.row = POS_W'(r1 - SUM_W'(ng));
        cand2.col = POS_W'(c1 - SUM_W'(ng));
        cand2.dir = DIR_DIAG;
        cand3.len = na;
        cand3.row = s2_item_reg.row;
        cand3.col = s2_item_reg.col;
        cand3.dir = DIR_ANTI;
        win01 = beats(cand1, cand0) ? cand1 : cand0;
        win23 = beats(cand3, cand2) ? cand3 : cand2;
        win   = beats(win23, win01) ? win23 : win01;
    end

    // ---------------- stage three: best run ----------------
    assign merged = (s3_cand_valid_reg && beats(s3_cand_reg, best_reg)) ? s3_cand_reg
                                                                        : best_reg;
    assign found  = (merged.len != '0);

    // line buffer write by stage two, read for the next request
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            down_mem[s2_item_reg.col] <= nd;
            diag_mem[s2_item_reg.col] <= ng;
            anti_mem[s2_item_reg.col] <= na;
        end
        if (advance) begin
            down_q_reg <= down_mem[head.col];
            diag_q_reg <= diag_mem[head.col];
            anti_q_reg <= anti_mem[head_anti_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_item_reg       <= head;
            down_byp_data_reg <= nd;
            diag_byp_data_reg <= ng;
            anti_byp_data_reg <= na;
            s3_last_reg       <= s2_item_reg.last;
            s3_cand_valid_reg <= s2_item_reg.letter;
            s3_cand_reg       <= win;
        end
        if (s3_valid_reg && advance && s3_last_reg) begin
            m_found_reg      <= found;
            m_run_length_reg <= found ? LEN_OUT_W'(merged.len) : '0;
            m_start_row_reg  <= found ? POS_OUT_W'(merged.row) : '0;
            m_start_col_reg  <= found ? POS_OUT_W'(merged.col) : '0;
            m_direction_reg  <= found ? DIR_W'(merged.dir) : DIR_W'(DIR_RIGHT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            down_byp_reg  <= 1'b0;
            diag_byp_reg  <= 1'b0;
            anti_byp_reg  <= 1'b0;
            left_run_reg  <= '0;
            diag_hold_reg <= '0;
            best_reg      <= BEST_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                s2_valid_reg <= q_valid;
                s3_valid_reg <= s2_valid_reg;
                // same-edge write to the address being read
                down_byp_reg <= wr_en && (s2_item_reg.col == head.col);
                diag_byp_reg <= wr_en && (s2_item_reg.col == head.col);
                anti_byp_reg <= wr_en && (s2_item_reg.col == head_anti_addr);
            end
            if (wr_en) begin
                if (s2_item_reg.last) begin
                    left_run_reg  <= '0;
                    diag_hold_reg <= '0;
                end else begin
                    left_run_reg  <= nr;
                    diag_hold_reg <= diag_val;
                end
            end
            if (s3_valid_reg && advance) begin
                best_reg <= s3_last_reg ? BEST_RESET : merged;
            end
            if (s3_valid_reg && advance && s3_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_run_length = m_run_length_reg;
    assign m_start_row  = m_start_row_reg;
    assign m_start_col  = m_start_col_reg;
    assign m_direction  = m_direction_reg;

endmodule

// ----- src/longest_letter_run_grid_scan_unit.sv -----
// Throughput: one grid cell per cycle, sustained with m_ready held high.
// The last cell passes the queue, stage two and stage three before the result is valid.
// The line buffer read-modify-write per column sets the one-cell step (same-edge bypass).
// Reset (synchronous, aresetn low): scan position, best run and result valid cleared,
// grid_rows and grid_cols return to 1024; line buffers are not cleared,
// as no entry is used before it has been written.
// ----------------------------------------------------------------------------
// longest_letter_run_grid_scan_unit
// Raster scan of a character grid for the longest run of letters in the
// right, down, down-right and up-right directions.
// ----------------------------------------------------------------------------
module longest_letter_run_grid_scan_unit
    import llrgs_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHAR_W-1:0]    s_cell_char,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_found,
    output logic [LEN_OUT_W-1:0] m_run_length,
    output logic [POS_OUT_W-1:0] m_start_row,
    output logic [POS_OUT_W-1:0] m_start_col,
    output logic [DIR_W-1:0]     m_direction,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  reg_index_t           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ITEM_W = 2 * $clog2(MAX_DIM) + 3;

    logic              q_push, q_full, q_pop, q_valid;
    logic [ITEM_W-1:0] q_in_data, q_out_data;

    llrgs_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cell_char (s_cell_char),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_push      (q_push),
        .q_data      (q_in_data),
        .q_full      (q_full)
    );

    llrgs_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_out_data)
    );

    llrgs_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_data       (q_out_data),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_run_length (m_run_length),
        .m_start_row  (m_start_row),
        .m_start_col  (m_start_col),
        .m_direction  (m_direction)
    );

endmodule

// ----- src/llrgs_checker.sv -----
// ----------------------------------------------------------------------------
// llrgs_checker
// Port-level checks on the result channel of the grid scan unit.
// ----------------------------------------------------------------------------
module llrgs_checker
    import llrgs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_found,
    input logic [LEN_OUT_W-1:0] m_run_length,
    input logic [POS_OUT_W-1:0] m_start_row,
    input logic [POS_OUT_W-1:0] m_start_col,
    input logic [DIR_W-1:0]     m_direction
);

    // stalled result holds
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_run_length)
            && $stable(m_start_row) && $stable(m_start_col) && $stable(m_direction))
        else $error("result changed while stalled");

    // no letter means an all-zero result
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_run_length == '0 && m_start_row == '0
            && m_start_col == '0 && m_direction == '0)
        else $error("empty grid result not zero");

    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_run_length != '0)
        else $error("found run with zero length");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind longest_letter_run_grid_scan_unit llrgs_checker u_checker (.*);
